// ----- src/odseq_pkg.sv -----
// odseq_pkg: shared constants, codes and types of the obstacle detour sequencer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package odseq_pkg;

  // angle scaling
  localparam int YAW_FRAC_BITS = 6;
  localparam int YAW_W         = 16;
  localparam int TURN_W        = 14;
  localparam int FWD_W         = 16;
  localparam int ATT_W         = 3;
  localparam int DIFF_W        = 20;

  localparam logic signed [DIFF_W-1:0] HALF_TURN     = DIFF_W'(180 * (1 << YAW_FRAC_BITS));
  localparam logic signed [DIFF_W-1:0] FULL_TURN     = DIFF_W'(360 * (1 << YAW_FRAC_BITS));
  localparam logic signed [DIFF_W-1:0] NEG_HALF_TURN = -HALF_TURN;

  localparam logic [ATT_W-1:0] ATT_MAX = '1;

  // phases
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_CW    = 2'd1;
  localparam logic [1:0] PH_FWD   = 2'd2;
  localparam logic [1:0] PH_CCW   = 2'd3;

  // motor commands
  localparam logic [1:0] CMD_KEEP = 2'd0;
  localparam logic [1:0] CMD_CW   = 2'd1;
  localparam logic [1:0] CMD_FWD  = 2'd2;
  localparam logic [1:0] CMD_CCW  = 2'd3;

  // verdicts
  localparam logic [1:0] VERDICT_KEEP   = 2'd0;
  localparam logic [1:0] VERDICT_RESUME = 2'd1;
  localparam logic [1:0] VERDICT_HALT   = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_ANGLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS  = 2'd2;

  localparam logic [TURN_W-1:0] TURN_ANGLE_RST    = 14'd5760;
  localparam logic [FWD_W-1:0]  FORWARD_TICKS_RST = 16'd1000;
  localparam logic [ATT_W-1:0]  MAX_ATTEMPTS_RST  = 3'd3;

  typedef struct packed {
    logic [TURN_W-1:0] turn_angle;
    logic [FWD_W-1:0]  forward_ticks;
    logic [ATT_W-1:0]  max_attempts;
  } odseq_cfg_t;

  typedef struct packed {
    logic [ATT_W-1:0] attempts_done;
    logic [1:0]       verdict;
    logic [1:0]       phase;
    logic [1:0]       motor_command;
  } odseq_result_t;

endpackage

// ----- src/odseq_turn_check.sv -----
// odseq_turn_check: wrapped heading difference and turn end compare
// depends on odseq_pkg
`timescale 1ns / 1ps

module odseq_turn_check (
  input  logic signed [odseq_pkg::YAW_W-1:0]  yaw_i,
  input  logic signed [odseq_pkg::YAW_W-1:0]  ref_i,
  input  logic        [odseq_pkg::TURN_W-1:0] turn_angle_i,
  output logic                                done_o
);
  import odseq_pkg::*;

  logic signed [DIFF_W-1:0] d0, d1, d2, d3, d4;
  logic        [DIFF_W-1:0] mag;

  always_comb begin
    d0  = DIFF_W'(yaw_i) - DIFF_W'(ref_i);
    d1  = (d0 > HALF_TURN) ? d0 - FULL_TURN : d0;
    d2  = (d1 > HALF_TURN) ? d1 - FULL_TURN : d1;
    d3  = (d2 < NEG_HALF_TURN) ? d2 + FULL_TURN : d2;
    d4  = (d3 < NEG_HALF_TURN) ? d3 + FULL_TURN : d3;
    mag = unsigned'((d4 < 0) ? -d4 : d4);
    done_o = mag >= DIFF_W'(turn_angle_i);
  end

endmodule

// ----- src/odseq_ctrl.sv -----
// odseq_ctrl: detour phase state and its per-tick update
// depends on odseq_pkg and odseq_turn_check
`timescale 1ns / 1ps

module odseq_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic signed [odseq_pkg::YAW_W-1:0] yaw_i,
  input  logic                               obstacle_i,
  input  odseq_pkg::odseq_cfg_t              cfg_i,
  output odseq_pkg::odseq_result_t           result_o
);
  import odseq_pkg::*;

  logic [1:0]               phase_q, phase_d;
  logic                     latched_q, latched_d;
  logic signed [YAW_W-1:0]  ref_q, ref_d;
  logic [FWD_W-1:0]         fcnt_q, fcnt_d;
  logic [ATT_W-1:0]         att_q, att_d;
  logic                     turn_done;
  logic [1:0]               cmd;
  logic [1:0]               verdict;

  odseq_turn_check u_turn_check (
    .yaw_i       (yaw_i),
    .ref_i       (ref_d),
    .turn_angle_i(cfg_i.turn_angle),
    .done_o      (turn_done)
  );

  // latch step, independent of the turn compare
  always_comb begin
    phase_d   = phase_q;
    latched_d = latched_q;
    ref_d     = ref_q;
    cmd       = CMD_KEEP;
    if (!latched_q) begin
      ref_d     = yaw_i;
      latched_d = 1'b1;
      if (phase_q == PH_START) begin
        phase_d = PH_CW;
        cmd     = CMD_CW;
      end else begin
        phase_d = PH_CCW;
        cmd     = CMD_CCW;
      end
    end
  end

  logic [1:0]       phase_n;
  logic             latched_n;
  logic [ATT_W-1:0] att_inc;

  always_comb begin
    phase_n   = phase_d;
    latched_n = latched_d;
    fcnt_d    = fcnt_q;
    att_d     = att_q;
    verdict   = VERDICT_KEEP;
    att_inc   = att_q;
    result_o.motor_command = cmd;
    if (phase_d == PH_CW && turn_done) begin
      result_o.motor_command = CMD_FWD;
      phase_n = PH_FWD;
      fcnt_d  = '0;
    end
    if (phase_n == PH_FWD && latched_d) begin
      if (fcnt_d >= cfg_i.forward_ticks) begin
        latched_n = 1'b0;
      end else begin
        fcnt_d = fcnt_d + 1'b1;
      end
    end
    if (phase_n == PH_CCW && turn_done) begin
      latched_n = 1'b0;
      phase_n   = PH_START;
      if (obstacle_i) begin
        att_inc = (att_q == ATT_MAX) ? att_q : att_q + 1'b1;
      end else begin
        att_inc = '0;
        verdict = VERDICT_RESUME;
      end
      att_d = att_inc;
      if (att_inc >= cfg_i.max_attempts) begin
        verdict = VERDICT_HALT;
        att_d   = '0;
      end
    end
    result_o.phase         = phase_n;
    result_o.verdict       = verdict;
    result_o.attempts_done = att_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      latched_q <= 1'b0;
      ref_q     <= '0;
      fcnt_q    <= '0;
      att_q     <= '0;
    end else if (en_i) begin
      phase_q   <= phase_n;
      latched_q <= latched_n;
      ref_q     <= ref_d;
      fcnt_q    <= fcnt_d;
      att_q     <= att_d;
    end
  end

endmodule

// ----- src/obstacle_detour_sequencer_core.sv -----
// obstacle_detour_sequencer_core: top level with stream ports, config registers
// depends on odseq_pkg and odseq_ctrl
`timescale 1ns / 1ps

// Usage
//   s_axis: one beat per control tick, yaw sample and obstacle flag.
//   m_axis: exactly one result beat per input beat, in order: motor command,
//           phase after the tick, verdict and attempt count.
//   cfg: write channel, always ready; index 0 turn angle, 1 forward ticks,
//        2 max attempts, other indexes are ignored. Write only while idle.
// Path: input beat to result beat through the input register, then the result
//   register holding the state update of the tick.
// Throughput: one beat per cycle while m_axis_tready stays high; the detour state
//   is updated in the single combinational pass between the two registers.
// Reset: phase start, no heading latched, counters zero, registers at their
//   defaults (turn angle 5760, forward ticks 1000, max attempts 3).
// Stall: when m_axis_tready is low the result register holds its beat; the
//   input register takes one more beat if it is empty, then s_axis_tready drops.

module obstacle_detour_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] yaw_angle, [16] obstacle_present, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] motor_command, [3:2] phase, [5:4] verdict, [8:6] attempts_done, [15:9] zero
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [odseq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import odseq_pkg::*;

  odseq_cfg_t              cfg_q;
  logic                    in_vld_q;
  logic signed [YAW_W-1:0] yaw_q;
  logic                    obs_q;
  logic                    out_vld_q;
  odseq_result_t           res_q, res_d;
  logic                    adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.turn_angle    <= TURN_ANGLE_RST;
      cfg_q.forward_ticks <= FORWARD_TICKS_RST;
      cfg_q.max_attempts  <= MAX_ATTEMPTS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TURN_ANGLE:    cfg_q.turn_angle    <= cfg_data_i[TURN_W-1:0];
        REG_FORWARD_TICKS: cfg_q.forward_ticks <= cfg_data_i[FWD_W-1:0];
        REG_MAX_ATTEMPTS:  cfg_q.max_attempts  <= cfg_data_i[ATT_W-1:0];
        default: ;
      endcase
    end
  end

  // result register frees up when empty or taken
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      yaw_q <= s_axis_tdata[YAW_W-1:0];
      obs_q <= s_axis_tdata[YAW_W];
    end
  end

  odseq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .yaw_i     (yaw_q),
    .obstacle_i(obs_q),
    .cfg_i     (cfg_q),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, res_q};

endmodule

// ----- sim/tb.sv -----
// tb: self-checking bench for obstacle_detour_sequencer_core, directed table then random detours
// depends on odseq_pkg and the core; results are checked against typed table values or an in-bench detour predictor
`timescale 1ns / 1ps

module tb;
  import odseq_pkg::*;

  localparam int HALF_SPAN  = 180 * (1 << YAW_FRAC_BITS);
  localparam int FULL_SPAN  = 360 * (1 << YAW_FRAC_BITS);
  localparam int PIPE_LAT   = 2;
  localparam int RAND_TICKS = 700;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [15:0]          reg_val;
    logic signed [15:0]   yaw;
    bit                   obs;
    bit                   typed;
    odseq_result_t        want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0] cfg_data_i;

  obstacle_detour_sequencer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // predictor copy of registers and detour state
  logic [TURN_W-1:0] turn_ang;
  logic [FWD_W-1:0]  fwd_ticks;
  logic [ATT_W-1:0]  max_att;
  logic [1:0]        det_phase;
  bit                latched;
  int                ref_hdg;
  logic [FWD_W-1:0]  fwd_cnt;
  logic [ATT_W-1:0]  att_cnt;

  odseq_result_t due_results[$];
  stim_row_t     dir_rows[$];
  int            err_count;
  odseq_result_t got_res;
  odseq_result_t want_res;

  function automatic bit heading_turned(int yaw);
    int d;
    int k;
    d = yaw - ref_hdg;
    k = 0;
    while (k < 2 && d > HALF_SPAN) begin
      d -= FULL_SPAN;
      k++;
    end
    k = 0;
    while (k < 2 && d < -HALF_SPAN) begin
      d += FULL_SPAN;
      k++;
    end
    if (d < 0) d = -d;
    return d >= int'(turn_ang);
  endfunction

  function automatic odseq_result_t advance_detour(logic signed [15:0] yaw_in, bit obs);
    odseq_result_t r;
    int yaw;
    yaw = yaw_in;
    r.motor_command = CMD_KEEP;
    r.verdict       = VERDICT_KEEP;
    if (!latched) begin
      ref_hdg = yaw;
      latched = 1'b1;
      if (det_phase == PH_START) begin
        det_phase = PH_CW;
        r.motor_command = CMD_CW;
      end else begin
        det_phase = PH_CCW;
        r.motor_command = CMD_CCW;
      end
    end
    if (det_phase == PH_CW && heading_turned(yaw)) begin
      r.motor_command = CMD_FWD;
      det_phase = PH_FWD;
      fwd_cnt = '0;
    end
    if (det_phase == PH_FWD && latched) begin
      if (fwd_cnt >= fwd_ticks) latched = 1'b0;
      else fwd_cnt = fwd_cnt + 1'b1;
    end
    if (det_phase == PH_CCW && heading_turned(yaw)) begin
      latched = 1'b0;
      det_phase = PH_START;
      if (obs) begin
        if (att_cnt < ATT_MAX) att_cnt = att_cnt + 1'b1;
      end else begin
        att_cnt = '0;
        r.verdict = VERDICT_RESUME;
      end
      if (att_cnt >= max_att) begin
        r.verdict = VERDICT_HALT;
        att_cnt = '0;
      end
    end
    r.phase         = det_phase;
    r.attempts_done = att_cnt;
    return r;
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    stim_row_t row;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    row.yaw     = '0;
    row.obs     = 1'b0;
    row.typed   = 1'b0;
    row.want    = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_free(logic signed [15:0] yaw, bit obs);
    stim_row_t row;
    row.kind    = ROW_TICK;
    row.reg_idx = REG_TURN_ANGLE;
    row.reg_val = '0;
    row.yaw     = yaw;
    row.obs     = obs;
    row.typed   = 1'b0;
    row.want    = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_typed(logic signed [15:0] yaw, bit obs, logic [1:0] cmd,
                                    logic [1:0] ph, logic [1:0] vd, logic [ATT_W-1:0] att);
    stim_row_t row;
    row.kind    = ROW_TICK;
    row.reg_idx = REG_TURN_ANGLE;
    row.reg_val = '0;
    row.yaw     = yaw;
    row.obs     = obs;
    row.typed   = 1'b1;
    row.want.motor_command = cmd;
    row.want.phase         = ph;
    row.want.verdict       = vd;
    row.want.attempts_done = att;
    dir_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  task automatic send_tick(input logic signed [15:0] yaw, input bit obs, input bit typed,
                           input odseq_result_t want, input int gap);
    odseq_result_t pred;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, obs, yaw};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = advance_detour(yaw, obs);
    due_results.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_TURN_ANGLE:    turn_ang  = val[TURN_W-1:0];
      REG_FORWARD_TICKS: fwd_ticks = val[FWD_W-1:0];
      REG_MAX_ATTEMPTS:  max_att   = val[ATT_W-1:0];
      default: ;
    endcase
  endtask

  // result beat checker
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata);
        err_count++;
      end else begin
        want_res = due_results.pop_front();
        got_res  = odseq_result_t'(m_axis_tdata[8:0]);
        check_field("motor_command", want_res.motor_command, got_res.motor_command);
        check_field("phase", want_res.phase, got_res.phase);
        check_field("verdict", want_res.verdict, got_res.verdict);
        check_field("attempts_done", want_res.attempts_done, got_res.attempts_done);
      end
    end
  end

  // receiver backpressure
  initial begin
    int run;
    int stall;
    int pick;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      pick = $urandom_range(0, 99);
      if (pick < 60) stall = $urandom_range(1, 2);
      else if (pick < 90) stall = $urandom_range(3, 6);
      else stall = $urandom_range(10, 30);
      m_axis_tready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    stim_row_t          row;
    odseq_result_t      none;
    logic signed [15:0] hdg;
    logic signed [15:0] yaw;
    logic [1:0]         hi;
    int n;
    int gap;
    int ta;
    int ft;
    int obs_pct;
    int stepmax;
    int dir;
    int sent;
    int pick;
    bit burst;
    bit obs;

    err_count = 0;
    none      = '0;
    turn_ang  = TURN_ANGLE_RST;
    fwd_ticks = FORWARD_TICKS_RST;
    max_att   = MAX_ATTEMPTS_RST;
    det_phase = PH_START;
    latched   = 1'b0;
    ref_hdg   = 0;
    fwd_cnt   = '0;
    att_cnt   = '0;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_TURN_ANGLE;
    cfg_data_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset defaults, zero turn, zero forward, zero attempts, extremes
    add_typed(16'sd0, 1'b1, CMD_CW, PH_CW, VERDICT_KEEP, 3'd0);
    add_cfg(REG_FORWARD_TICKS, 16'd0);
    add_typed(-16'sd5760, 1'b1, CMD_FWD, PH_FWD, VERDICT_KEEP, 3'd0);
    add_typed(16'sd0, 1'b1, CMD_CCW, PH_CCW, VERDICT_KEEP, 3'd0);
    add_free(16'sd32767, 1'b1);
    add_cfg(REG_TURN_ANGLE, 16'd0);
    add_typed(16'sh8000, 1'b0, CMD_FWD, PH_FWD, VERDICT_KEEP, 3'd1);
    add_typed(16'sd100, 1'b0, CMD_CCW, PH_START, VERDICT_RESUME, 3'd0);
    add_cfg(REG_MAX_ATTEMPTS, 16'd0);
    add_typed(16'sd200, 1'b1, CMD_FWD, PH_FWD, VERDICT_KEEP, 3'd0);
    add_typed(16'sd300, 1'b1, CMD_CCW, PH_START, VERDICT_HALT, 3'd0);
    add_cfg(REG_MAX_ATTEMPTS, 16'd7);
    add_cfg(REG_TURN_ANGLE, 16'd11520);
    add_typed(16'sd0, 1'b0, CMD_CW, PH_CW, VERDICT_KEEP, 3'd0);
    add_free(16'sd11519, 1'b0);
    add_free(-16'sd11520, 1'b1);
    add_free(16'sd23040, 1'b1);
    add_free(-16'sd11520, 1'b1);
    add_cfg(REG_FORWARD_TICKS, 16'd65535);
    add_cfg(REG_TURN_ANGLE, 16'd0);
    add_free(16'sd1, 1'b0);
    add_free(16'sd2, 1'b0);
    add_cfg(REG_FORWARD_TICKS, 16'd1);
    add_free(16'sd3, 1'b0);
    add_free(-16'sd1, 1'b0);
    add_cfg(2'd3, 16'hffff);
    add_cfg(REG_MAX_ATTEMPTS, 16'hfff9);
    add_free(16'sh7fff, 1'b1);
    add_free(16'sh8000, 1'b1);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) write_reg(row.reg_idx, row.reg_val);
      else send_tick(row.yaw, row.obs, row.typed, row.want, $urandom_range(0, 2));
    end

    // random detours, new register setting per stretch
    sent = 0;
    hdg  = '0;
    while (sent < RAND_TICKS) begin
      case ($urandom_range(0, 3))
        0: ta = 0;
        1: ta = 11520;
        2: ta = $urandom_range(0, 11520);
        default: ta = $urandom_range(1, 600);
      endcase
      hi = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'b00;
      write_reg(REG_TURN_ANGLE, {hi, 14'(ta)});
      case ($urandom_range(0, 3))
        0: ft = 0;
        1: ft = 1;
        2: ft = $urandom_range(2, 6);
        default: ft = $urandom_range(7, 30);
      endcase
      write_reg(REG_FORWARD_TICKS, 16'(ft));
      write_reg(REG_MAX_ATTEMPTS, 16'($urandom_range(0, 7)));

      case ($urandom_range(0, 3))
        0: obs_pct = 0;
        1: obs_pct = 30;
        2: obs_pct = 70;
        default: obs_pct = 100;
      endcase
      burst   = ($urandom_range(0, 3) == 0);
      stepmax = ta / 3 + 32;
      dir     = $urandom_range(0, 1) ? 1 : -1;
      n       = $urandom_range(40, 60);
      repeat (n) begin
        if ($urandom_range(0, 15) == 0) dir = -dir;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          hdg = hdg + 16'(dir * $urandom_range(0, stepmax));
          yaw = hdg;
        end else if (pick < 90) begin
          yaw = 16'($urandom);
        end else begin
          case ($urandom_range(0, 4))
            0: yaw = -16'sd11520;
            1: yaw = 16'sd23040;
            2: yaw = 16'sh8000;
            3: yaw = 16'sh7fff;
            default: yaw = 16'sd0;
          endcase
        end
        obs  = ($urandom_range(0, 99) < obs_pct);
        pick = $urandom_range(0, 99);
        if (burst || pick < 50) gap = 0;
        else if (pick < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(4, 20);
        send_tick(yaw, obs, 1'b0, none, gap);
        sent++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 8) @(posedge clk_i);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/odseq_pkg.sv
src/odseq_turn_check.sv
src/odseq_ctrl.sv
src/obstacle_detour_sequencer_core.sv
sim/tb.sv
